// ===== src/i2cms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int CNT_W         = $clog2(BITS_PER_BYTE);
    localparam int CMD_W         = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_START     = 3'd0,
        CMD_STOP      = 3'd1,
        CMD_SEND_BYTE = 3'd2,
        CMD_RECV_BYTE = 3'd3,
        CMD_SEND_ACK  = 3'd4,
        CMD_RECV_ACK  = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_SDA_HI,
        ST_START_SCL_HI,
        ST_START_SDA_LO,
        ST_START_SCL_LO,
        ST_STOP_SDA_LO,
        ST_STOP_SCL_HI,
        ST_STOP_SDA_HI,
        ST_BIT_SDA,
        ST_BIT_SCL_HI,
        ST_BIT_SAMPLE,
        ST_BIT_SCL_LO
    } t_state;

    typedef enum logic [1:0] {
        SDA_ONE,
        SDA_ZERO,
        SDA_TX,
        SDA_ACK
    } t_sda_sel;

    // Controller to datapath.
    typedef struct packed {
        logic     load;
        logic     ack_cmd;
        logic     emit;
        logic     set_scl;
        logic     scl_val;
        logic     set_sda;
        t_sda_sel sda_sel;
        logic     sample;
        logic     last;
        logic     shift_bit;
        logic     show_rx;
        logic     show_ack;
    } t_dp_ctl;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
        logic bit_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== src/i2cms_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cms_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [i2cms_pkg::CMD_W-1:0] i_command,
    output logic                            o_in_ready,
    input  wire i2cms_pkg::t_dp_stat        i_stat,
    output i2cms_pkg::t_dp_ctl              o_ctl
);

    i2cms_pkg::t_state r_state, n_state;
    i2cms_pkg::t_cmd   r_cmd, n_cmd;
    i2cms_pkg::t_cmd   in_cmd;
    logic              accept;
    logic              step_ok;

    assign in_cmd     = i2cms_pkg::t_cmd'(i_command);
    assign o_in_ready = (r_state == i2cms_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign step_ok    = i_stat.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2cms_pkg::ST_IDLE;
            r_cmd   <= i2cms_pkg::CMD_START;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        unique case (r_state)
            i2cms_pkg::ST_IDLE: begin
                if (accept) begin
                    n_cmd = in_cmd;
                    unique case (in_cmd)
                        i2cms_pkg::CMD_START:     n_state = i2cms_pkg::ST_START_SDA_HI;
                        i2cms_pkg::CMD_STOP:      n_state = i2cms_pkg::ST_STOP_SDA_LO;
                        i2cms_pkg::CMD_SEND_BYTE,
                        i2cms_pkg::CMD_RECV_BYTE,
                        i2cms_pkg::CMD_SEND_ACK,
                        i2cms_pkg::CMD_RECV_ACK:  n_state = i2cms_pkg::ST_BIT_SDA;
                        default: begin
                            n_state = i2cms_pkg::ST_IDLE;
                            n_cmd   = r_cmd;
                        end
                    endcase
                end
            end
            i2cms_pkg::ST_START_SDA_HI: if (step_ok) n_state = i2cms_pkg::ST_START_SCL_HI;
            i2cms_pkg::ST_START_SCL_HI: if (step_ok) n_state = i2cms_pkg::ST_START_SDA_LO;
            i2cms_pkg::ST_START_SDA_LO: if (step_ok) n_state = i2cms_pkg::ST_START_SCL_LO;
            i2cms_pkg::ST_START_SCL_LO: if (step_ok) n_state = i2cms_pkg::ST_IDLE;
            i2cms_pkg::ST_STOP_SDA_LO:  if (step_ok) n_state = i2cms_pkg::ST_STOP_SCL_HI;
            i2cms_pkg::ST_STOP_SCL_HI:  if (step_ok) n_state = i2cms_pkg::ST_STOP_SDA_HI;
            i2cms_pkg::ST_STOP_SDA_HI:  if (step_ok) n_state = i2cms_pkg::ST_IDLE;
            i2cms_pkg::ST_BIT_SDA:      if (step_ok) n_state = i2cms_pkg::ST_BIT_SCL_HI;
            i2cms_pkg::ST_BIT_SCL_HI: begin
                if (step_ok) begin
                    if (r_cmd == i2cms_pkg::CMD_RECV_BYTE || r_cmd == i2cms_pkg::CMD_RECV_ACK)
                        n_state = i2cms_pkg::ST_BIT_SAMPLE;
                    else
                        n_state = i2cms_pkg::ST_BIT_SCL_LO;
                end
            end
            i2cms_pkg::ST_BIT_SAMPLE:   if (step_ok) n_state = i2cms_pkg::ST_BIT_SCL_LO;
            i2cms_pkg::ST_BIT_SCL_LO: begin
                if (step_ok) begin
                    if (i_stat.bit_last)
                        n_state = i2cms_pkg::ST_IDLE;
                    else if (r_cmd == i2cms_pkg::CMD_RECV_BYTE)
                        n_state = i2cms_pkg::ST_BIT_SCL_HI;
                    else
                        n_state = i2cms_pkg::ST_BIT_SDA;
                end
            end
            default: n_state = i2cms_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_ctl         = '0;
        o_ctl.sda_sel = i2cms_pkg::SDA_ONE;
        o_ctl.load    = accept;
        o_ctl.ack_cmd = (in_cmd == i2cms_pkg::CMD_SEND_ACK) ||
                        (in_cmd == i2cms_pkg::CMD_RECV_ACK);
        unique case (r_state)
            i2cms_pkg::ST_IDLE: ;
            i2cms_pkg::ST_START_SDA_HI: begin
                o_ctl.set_sda = 1'b1;
            end
            i2cms_pkg::ST_START_SCL_HI,
            i2cms_pkg::ST_STOP_SCL_HI,
            i2cms_pkg::ST_BIT_SCL_HI: begin
                o_ctl.set_scl = 1'b1;
                o_ctl.scl_val = 1'b1;
            end
            i2cms_pkg::ST_START_SDA_LO,
            i2cms_pkg::ST_STOP_SDA_LO: begin
                o_ctl.set_sda = 1'b1;
                o_ctl.sda_sel = i2cms_pkg::SDA_ZERO;
            end
            i2cms_pkg::ST_START_SCL_LO: begin
                o_ctl.set_scl = 1'b1;
                o_ctl.last    = 1'b1;
            end
            i2cms_pkg::ST_STOP_SDA_HI: begin
                o_ctl.set_sda = 1'b1;
                o_ctl.last    = 1'b1;
            end
            i2cms_pkg::ST_BIT_SDA: begin
                o_ctl.set_sda = 1'b1;
                if (r_cmd == i2cms_pkg::CMD_SEND_BYTE)
                    o_ctl.sda_sel = i2cms_pkg::SDA_TX;
                else if (r_cmd == i2cms_pkg::CMD_SEND_ACK)
                    o_ctl.sda_sel = i2cms_pkg::SDA_ACK;
            end
            i2cms_pkg::ST_BIT_SAMPLE: begin
                o_ctl.sample = 1'b1;
            end
            i2cms_pkg::ST_BIT_SCL_LO: begin
                o_ctl.set_scl   = 1'b1;
                o_ctl.last      = i_stat.bit_last;
                o_ctl.shift_bit = 1'b1;
                o_ctl.show_rx   = i_stat.bit_last && (r_cmd == i2cms_pkg::CMD_RECV_BYTE);
                o_ctl.show_ack  = i_stat.bit_last && (r_cmd == i2cms_pkg::CMD_RECV_ACK);
            end
            default: ;
        endcase
        o_ctl.emit = step_ok && (r_state != i2cms_pkg::ST_IDLE);
        if (!o_ctl.emit) begin
            o_ctl.set_scl   = 1'b0;
            o_ctl.set_sda   = 1'b0;
            o_ctl.sample    = 1'b0;
            o_ctl.shift_bit = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== src/i2cms_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cms_dpath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire i2cms_pkg::t_dp_ctl                 i_ctl,
    output i2cms_pkg::t_dp_stat                     o_stat,
    input  wire logic [i2cms_pkg::BITS_PER_BYTE-1:0] i_tx_byte,
    input  wire logic                               i_ack_level,
    input  wire logic [i2cms_pkg::BITS_PER_BYTE-1:0] i_sda_samples,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output logic                                    o_scl_level,
    output logic                                    o_sda_level,
    output logic                                    o_sample_phase,
    output logic                                    o_last_phase,
    output logic [i2cms_pkg::BITS_PER_BYTE-1:0]     o_rx_byte,
    output logic                                    o_ack_seen
);

    localparam int BW = i2cms_pkg::BITS_PER_BYTE;
    localparam int CW = i2cms_pkg::CNT_W;

    logic          r_scl, r_sda;
    logic          n_scl, n_sda;
    logic [BW-1:0] r_tx, r_smp, r_rx;
    logic          r_ack_lvl, r_ack_smp;
    logic [CW-1:0] r_cnt;
    logic          r_out_valid;
    logic          r_o_scl, r_o_sda, r_o_samp, r_o_last, r_o_ack;
    logic [BW-1:0] r_o_rx;

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.bit_last = (r_cnt == CW'(BW - 1));

    always_comb begin
        n_scl = i_ctl.set_scl ? i_ctl.scl_val : r_scl;
        n_sda = r_sda;
        if (i_ctl.set_sda) begin
            case (i_ctl.sda_sel)
                i2cms_pkg::SDA_ONE:  n_sda = 1'b1;
                i2cms_pkg::SDA_ZERO: n_sda = 1'b0;
                i2cms_pkg::SDA_TX:   n_sda = r_tx[BW-1];
                i2cms_pkg::SDA_ACK:  n_sda = r_ack_lvl;
                default:             n_sda = r_sda;
            endcase
        end
    end

    // Control state: bus lines, bit counter, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_scl <= n_scl;
            r_sda <= n_sda;
            if (i_ctl.load)
                r_cnt <= i_ctl.ack_cmd ? CW'(BW - 1) : '0;
            else if (i_ctl.shift_bit && !o_stat.bit_last)
                r_cnt <= r_cnt + 1'b1;
            if (i_ctl.emit)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    // Payload: operand shifters and the output word.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_tx      <= i_tx_byte;
            r_smp     <= i_sda_samples;
            r_ack_lvl <= i_ack_level;
            r_ack_smp <= i_sda_samples[0];
        end else begin
            if (i_ctl.shift_bit)
                r_tx <= {r_tx[BW-2:0], 1'b0};
            if (i_ctl.sample) begin
                r_smp <= {r_smp[BW-2:0], 1'b0};
                r_rx  <= {r_rx[BW-2:0], r_smp[BW-1]};
            end
        end
        if (i_ctl.emit) begin
            r_o_scl  <= n_scl;
            r_o_sda  <= n_sda;
            r_o_samp <= i_ctl.sample;
            r_o_last <= i_ctl.last;
            r_o_rx   <= i_ctl.show_rx ? r_rx : '0;
            r_o_ack  <= i_ctl.show_ack && r_ack_smp;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scl_level    = r_o_scl;
    assign o_sda_level    = r_o_sda;
    assign o_sample_phase = r_o_samp;
    assign o_last_phase   = r_o_last;
    assign o_rx_byte      = r_o_rx;
    assign o_ack_seen     = r_o_ack;

endmodule

`default_nettype wire

// ===== src/i2c_master_bit_sequencer.sv =====
// Order: the first phase word of a command is registered from the first phase state,
// which the controller enters from idle when it accepts the command; one phase word
// follows per cycle while the output is not stalled. A command is taken only in idle,
// so none is taken while the phase run of the previous one is under way; an undefined
// command is dropped and the block stays ready. A new command is taken the
// cycle after the last phase of the previous one is registered. Reset releases both lines.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Command input.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: [7:0] tx_byte, [8] ack_level, [16:9] sda_samples, [23:17] zero.
    input  wire logic [23:0] s_axis_tdata,
    // tuser: [2:0] command.
    input  wire logic [2:0]  s_axis_tuser,
    // Phase output.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: [0] scl_level, [1] sda_level, [9:2] rx_byte, [10] ack_seen, [15:11] zero.
    output logic [15:0]      m_axis_tdata,
    // tuser: [0] sample_phase.
    output logic             m_axis_tuser,
    // tlast: last_phase, marks the final phase of a command.
    output logic             m_axis_tlast
);

    localparam int BW = i2cms_pkg::BITS_PER_BYTE;

    i2cms_pkg::t_dp_ctl  ctl;
    i2cms_pkg::t_dp_stat stat;
    logic                scl_level, sda_level, ack_seen;
    logic [BW-1:0]       rx_byte;

    // The controller walks the phase run of each command; the datapath holds the
    // bus line levels, the byte shifters and the output word register.
    i2cms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_command  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    i2cms_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_stat         (stat),
        .i_tx_byte      (s_axis_tdata[BW-1:0]),
        .i_ack_level    (s_axis_tdata[BW]),
        .i_sda_samples  (s_axis_tdata[2*BW:BW+1]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_scl_level    (scl_level),
        .o_sda_level    (sda_level),
        .o_sample_phase (m_axis_tuser),
        .o_last_phase   (m_axis_tlast),
        .o_rx_byte      (rx_byte),
        .o_ack_seen     (ack_seen)
    );

    assign m_axis_tdata = {5'b0, ack_seen, rx_byte, sda_level, scl_level};

    // A sample phase always happens with SCL released high.
    a_sample_scl_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[0])
        else $error("sample phase with SCL low");

    // A received ack bit is only reported on the final phase of a command.
    a_ack_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[10]) |-> m_axis_tlast)
        else $error("ack_seen set on a non-final phase");

    // An undefined command is dropped and the sequencer is ready again at once.
    a_bad_cmd_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser > i2cms_pkg::CMD_RECV_ACK))
        |=> s_axis_tready)
        else $error("undefined command started a phase run");

    // The final phase of every command leaves SCL low, except stop which releases both.
    a_last_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast && m_axis_tdata[0]) |-> m_axis_tdata[1])
        else $error("final phase with SCL high but SDA low");

endmodule

`default_nettype wire

// ===== sim/tb_i2c_master_bit_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_i2c_master_bit_sequencer;

    // Command codes that the package leaves undefined; the block must drop them.
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    // Longest stretch without any word accepted on either side before the run is
    // declared hung. The deliberate sink hold is far shorter than this.
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    // Ample slack for a stray word to show up after the last expected one.
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_REPORTS = 40;

    // One command word as the sender sees it.
    typedef struct {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic [7:0] sda_samples;
    } t_cmd_word;

    // One expected phase word.
    typedef struct {
        logic       scl;
        logic       sda;
        logic       sample;
        logic       last;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } t_phase_word;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: [7:0] tx_byte, [8] ack_level, [16:9] sda_samples, [23:17] zero.
    logic [23:0] s_axis_tdata  = '0;
    // tuser: [2:0] command.
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: [0] scl_level, [1] sda_level, [9:2] rx_byte, [10] ack_seen, [15:11] zero.
    logic [15:0] m_axis_tdata;
    // tuser: [0] sample_phase.
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // Commands waiting to be offered, and phase words still owed by the block.
    t_cmd_word   cmd_q[$];
    t_phase_word owed_phases[$];

    // Line levels as the predictor tracks them; both lines come out of reset released.
    logic        line_scl = 1'b1;
    logic        line_sda = 1'b1;

    // Idling controls, set by the stimulus between phases.
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          hold_req = 0;
    int          hold_ack = 0;
    int          hold_left = 0;

    int          err_cnt = 0;
    int          phases_checked = 0;
    int          idle_cycles = 0;
    int          cmd_cnt [8] = '{default: 0};

    i2c_master_bit_sequencer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Phase predictor. Each command expands into its fixed run of line
    // changes; a sample phase leaves both lines where they are.
    // ------------------------------------------------------------------
    function automatic void owe_phase(logic sample, logic last, logic [7:0] rx, logic ack);
        t_phase_word p;
        p.scl      = line_scl;
        p.sda      = line_sda;
        p.sample   = sample;
        p.last     = last;
        p.rx_byte  = rx;
        p.ack_seen = ack;
        owed_phases.push_back(p);
    endfunction

    function automatic void expand_command(logic [2:0] cmd, logic [7:0] tx, logic ack_lvl,
                                           logic [7:0] smp);
        case (cmd)
            i2cms_pkg::CMD_START: begin
                line_sda = 1'b1; owe_phase(1'b0, 1'b0, 8'd0, 1'b0);
                line_scl = 1'b1; owe_phase(1'b0, 1'b0, 8'd0, 1'b0);
                line_sda = 1'b0; owe_phase(1'b0, 1'b0, 8'd0, 1'b0);
                line_scl = 1'b0; owe_phase(1'b0, 1'b1, 8'd0, 1'b0);
            end
            i2cms_pkg::CMD_STOP: begin
                line_sda = 1'b0; owe_phase(1'b0, 1'b0, 8'd0, 1'b0);
                line_scl = 1'b1; owe_phase(1'b0, 1'b0, 8'd0, 1'b0);
                line_sda = 1'b1; owe_phase(1'b0, 1'b1, 8'd0, 1'b0);
            end
            i2cms_pkg::CMD_SEND_BYTE: begin
                for (int i = 7; i >= 0; i--) begin
                    line_sda = tx[i];  owe_phase(1'b0, 1'b0, 8'd0, 1'b0);
                    line_scl = 1'b1;   owe_phase(1'b0, 1'b0, 8'd0, 1'b0);
                    line_scl = 1'b0;   owe_phase(1'b0, i == 0, 8'd0, 1'b0);
                end
            end
            i2cms_pkg::CMD_RECV_BYTE: begin
                // SDA is released once, then every bit is a clock pulse with a
                // sample in the middle. The whole byte shows only on the last phase.
                line_sda = 1'b1; owe_phase(1'b0, 1'b0, 8'd0, 1'b0);
                for (int i = 7; i >= 0; i--) begin
                    line_scl = 1'b1; owe_phase(1'b0, 1'b0, 8'd0, 1'b0);
                    owe_phase(1'b1, 1'b0, 8'd0, 1'b0);
                    line_scl = 1'b0; owe_phase(1'b0, i == 0, (i == 0) ? smp : 8'd0, 1'b0);
                end
            end
            i2cms_pkg::CMD_SEND_ACK: begin
                line_sda = ack_lvl; owe_phase(1'b0, 1'b0, 8'd0, 1'b0);
                line_scl = 1'b1;    owe_phase(1'b0, 1'b0, 8'd0, 1'b0);
                line_scl = 1'b0;    owe_phase(1'b0, 1'b1, 8'd0, 1'b0);
            end
            i2cms_pkg::CMD_RECV_ACK: begin
                line_sda = 1'b1; owe_phase(1'b0, 1'b0, 8'd0, 1'b0);
                line_scl = 1'b1; owe_phase(1'b0, 1'b0, 8'd0, 1'b0);
                owe_phase(1'b1, 1'b0, 8'd0, 1'b0);
                line_scl = 1'b0; owe_phase(1'b0, 1'b1, 8'd0, smp[0]);
            end
            default: begin
                // Undefined commands produce nothing and leave the lines alone.
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("%0t: %s mismatch, got 'h%0h, expected 'h%0h (phase word %0d)",
                     $time, what, got, want, phases_checked);
    endtask

    // ------------------------------------------------------------------
    // Command driver. A new word is offered only when the slot is free, so
    // tvalid never drops while a word is waiting to be taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cmd_word w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                w = cmd_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, w.sda_samples, w.ack_level, w.tx_byte};
                s_axis_tuser  <= w.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Phase sink. A hold request from the stimulus makes it refuse words for a
    // long stretch so the block backs up and stops taking commands.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Commands are expanded at the edge where they are accepted,
    // and each accepted phase word is checked against the oldest one owed.
    // Both sides live in one process so the queue sees a fixed order.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_phase_word e;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                cmd_cnt[s_axis_tuser]++;
                expand_command(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8],
                               s_axis_tdata[16:9]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (owed_phases.size() == 0) begin
                    report_mismatch("unexpected phase word", int'(m_axis_tdata), 0);
                end else begin
                    e = owed_phases.pop_front();
                    if (m_axis_tdata[0] !== e.scl)
                        report_mismatch("scl_level", int'(m_axis_tdata[0]), int'(e.scl));
                    if (m_axis_tdata[1] !== e.sda)
                        report_mismatch("sda_level", int'(m_axis_tdata[1]), int'(e.sda));
                    if (m_axis_tdata[9:2] !== e.rx_byte)
                        report_mismatch("rx_byte", int'(m_axis_tdata[9:2]), int'(e.rx_byte));
                    if (m_axis_tdata[10] !== e.ack_seen)
                        report_mismatch("ack_seen", int'(m_axis_tdata[10]),
                                        int'(e.ack_seen));
                    if (m_axis_tdata[15:11] !== 5'd0)
                        report_mismatch("tdata padding", int'(m_axis_tdata[15:11]), 0);
                    if (m_axis_tuser !== e.sample)
                        report_mismatch("sample_phase", int'(m_axis_tuser), int'(e.sample));
                    if (m_axis_tlast !== e.last)
                        report_mismatch("last_phase", int'(m_axis_tlast), int'(e.last));
                end
                phases_checked++;
            end
        end
    end

    // Watchdog: a run where no word moves on either side for too long is hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d phase words still owed",
                     $time, STALL_LIMIT, owed_phases.size());
            $display("[i2c_master_bit_sequencer] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    function automatic void push_cmd(logic [2:0] cmd, logic [7:0] tx, logic ack_lvl,
                                     logic [7:0] smp);
        t_cmd_word w;
        w.cmd         = cmd;
        w.tx_byte     = tx;
        w.ack_level   = ack_lvl;
        w.sda_samples = smp;
        cmd_q.push_back(w);
    endfunction

    // Queues one command with random values in every field it does not use.
    function automatic void push_rand(logic [2:0] cmd);
        push_cmd(cmd, 8'($urandom), 1'($urandom), 8'($urandom));
    endfunction

    // Queues one bus transaction with random content: start, address, ack,
    // a few data bytes in one direction, stop. Now and then a stray command
    // is thrown in or the stop is left out, so the next start is a repeated
    // start. Returns the number of defined commands queued.
    function automatic int queue_transaction();
        int         n = 0;
        int         nbytes;
        bit         rd;
        logic [2:0] stray;
        rd     = 1'($urandom_range(1));
        nbytes = $urandom_range(1, 3);
        push_rand(i2cms_pkg::CMD_START);
        push_rand(i2cms_pkg::CMD_SEND_BYTE);
        push_rand(i2cms_pkg::CMD_RECV_ACK);
        n += 3;
        for (int i = 0; i < nbytes; i++) begin
            if (rd) begin
                push_rand(i2cms_pkg::CMD_RECV_BYTE);
                // Master acks every byte but the last of the read.
                push_cmd(i2cms_pkg::CMD_SEND_ACK, 8'($urandom), i == nbytes - 1,
                         8'($urandom));
            end else begin
                push_rand(i2cms_pkg::CMD_SEND_BYTE);
                push_rand(i2cms_pkg::CMD_RECV_ACK);
            end
            n += 2;
            if ($urandom_range(7) == 0) begin
                stray = 3'($urandom_range(7));
                push_rand(stray);
                if (stray != CMD_RSVD_6 && stray != CMD_RSVD_7)
                    n++;
            end
        end
        if ($urandom_range(9) != 0) begin
            push_rand(i2cms_pkg::CMD_STOP);
            n++;
        end
        return n;
    endfunction

    // Returns once every command has been taken and every phase word has come.
    task automatic wait_drained();
        while (cmd_q.size() != 0 || s_axis_tvalid || owed_phases.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input int goal,
                             input bit long_hold);
        int n;
        n = 0;
        @(negedge i_clk);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        while (n < goal)
            n += queue_transaction();
        if (long_hold)
            hold_req++;
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words, back to back: stop with the lines already released,
        // byte extremes both ways, ack and nack, a receive ack whose other
        // sample bits must be ignored, a repeated start with SCL low,
        // and undefined commands between defined ones.
        push_cmd(i2cms_pkg::CMD_STOP,      8'h00, 1'b0, 8'h00);
        push_cmd(i2cms_pkg::CMD_START,     8'hFF, 1'b1, 8'hFF);
        push_cmd(i2cms_pkg::CMD_SEND_BYTE, 8'h00, 1'b1, 8'hFF);
        push_cmd(i2cms_pkg::CMD_SEND_BYTE, 8'hFF, 1'b0, 8'h00);
        push_cmd(i2cms_pkg::CMD_SEND_BYTE, 8'hA5, 1'b0, 8'h00);
        push_cmd(i2cms_pkg::CMD_RECV_ACK,  8'h00, 1'b0, 8'h00);
        push_cmd(i2cms_pkg::CMD_RECV_ACK,  8'h00, 1'b0, 8'h01);
        push_cmd(i2cms_pkg::CMD_RECV_ACK,  8'hFF, 1'b1, 8'hFE);
        push_cmd(i2cms_pkg::CMD_RECV_BYTE, 8'h00, 1'b0, 8'h00);
        push_cmd(i2cms_pkg::CMD_RECV_BYTE, 8'h00, 1'b0, 8'hFF);
        push_cmd(i2cms_pkg::CMD_RECV_BYTE, 8'hFF, 1'b1, 8'h5A);
        push_cmd(i2cms_pkg::CMD_SEND_ACK,  8'hFF, 1'b0, 8'hFF);
        push_cmd(i2cms_pkg::CMD_SEND_ACK,  8'h00, 1'b1, 8'h00);
        push_cmd(i2cms_pkg::CMD_START,     8'h00, 1'b0, 8'h00);
        push_cmd(CMD_RSVD_6,               8'hFF, 1'b1, 8'hFF);
        push_cmd(CMD_RSVD_7,               8'h00, 1'b0, 8'h00);
        push_cmd(i2cms_pkg::CMD_STOP,      8'hFF, 1'b1, 8'hFF);
        push_cmd(i2cms_pkg::CMD_STOP,      8'h00, 1'b0, 8'h00);
        push_cmd(i2cms_pkg::CMD_START,     8'h00, 1'b0, 8'h00);
        push_cmd(CMD_RSVD_6,               8'h3C, 1'b0, 8'hC3);
        push_cmd(i2cms_pkg::CMD_SEND_BYTE, 8'h5A, 1'b1, 8'hA5);
        push_cmd(i2cms_pkg::CMD_RECV_ACK,  8'h00, 1'b0, 8'hFF);
        push_cmd(i2cms_pkg::CMD_STOP,      8'h00, 1'b0, 8'h00);
        wait_drained();

        // Random transactions under four idling patterns. The first one also
        // holds the sink off for a long stretch while commands keep coming.
        run_phase(0, 0, 72, 1'b1);
        run_phase(47, 0, 72, 1'b0);
        run_phase(0, 47, 72, 1'b0);
        run_phase(27, 27, 72, 1'b0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (owed_phases.size() != 0)
            report_mismatch("phase words never delivered", 0, owed_phases.size());

        $display("Ran %0d start, %0d stop, %0d send byte, %0d receive byte, %0d send ack,",
                 cmd_cnt[i2cms_pkg::CMD_START], cmd_cnt[i2cms_pkg::CMD_STOP],
                 cmd_cnt[i2cms_pkg::CMD_SEND_BYTE], cmd_cnt[i2cms_pkg::CMD_RECV_BYTE],
                 cmd_cnt[i2cms_pkg::CMD_SEND_ACK]);
        $display("%0d receive ack and %0d undefined commands; %0d phase words checked.",
                 cmd_cnt[i2cms_pkg::CMD_RECV_ACK], cmd_cnt[CMD_RSVD_6] + cmd_cnt[CMD_RSVD_7],
                 phases_checked);
        if (err_cnt == 0) begin
            $display("[i2c_master_bit_sequencer] OK");
        end else begin
            $display("[i2c_master_bit_sequencer] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
